// ===== rtl/tts_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the thread table scheduler
package tts_pkg;

    localparam logic [1:0] CMD_CREATE  = 2'd0;
    localparam logic [1:0] CMD_YIELD   = 2'd1;
    localparam logic [1:0] CMD_DESTROY = 2'd2;
    localparam logic [1:0] CMD_SCHED   = 2'd3;

    localparam logic [1:0] MODE_RR   = 2'd0;
    localparam logic [1:0] MODE_PRIO = 2'd1;

    localparam int TID_W = 4;

    typedef enum logic [1:0] {
        SLOT_FREE  = 2'd0,
        SLOT_RUN   = 2'd1,
        SLOT_YIELD = 2'd2
    } slot_state_t;

    typedef enum logic [1:0] {
        PICK_FREE = 2'd0,
        PICK_RR   = 2'd1,
        PICK_PRIO = 2'd2,
        PICK_FCFS = 2'd3
    } pick_mode_t;

    typedef struct packed {
        logic       start;
        logic       cand_vld;
        pick_mode_t mode;
    } pick_ctrl_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  prio;
        logic [31:0] now;
    } tts_in_t;

    typedef struct packed {
        logic [TID_W-1:0] tid;
        logic             ok;
    } tts_out_t;

endpackage

// ===== rtl/tts_slot_mem.sv =====
`timescale 1ns / 1ps
// per-slot priority and arrival time storage, one write and one registered read port
module tts_slot_mem #(
    parameter int SLOTS = 16,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [7:0]       wr_prio,
    input  logic [31:0]      wr_arrival,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [7:0]       rd_prio,
    output logic [31:0]      rd_arrival
);

    logic [7:0]  prio_mem    [SLOTS];
    logic [31:0] arrival_mem [SLOTS];
    logic [7:0]  rd_prio_reg;
    logic [31:0] rd_arrival_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            prio_mem[wr_addr]    <= wr_prio;
            arrival_mem[wr_addr] <= wr_arrival;
        end
        rd_prio_reg    <= prio_mem[rd_addr];
        rd_arrival_reg <= arrival_mem[rd_addr];
    end

    assign rd_prio    = rd_prio_reg;
    assign rd_arrival = rd_arrival_reg;

endmodule

// ===== rtl/tts_picker.sv =====
`timescale 1ns / 1ps
// shared compare unit that keeps the best slot seen so far during a scan
module tts_picker import tts_pkg::*; #(
    parameter int SLOTS = 16,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  pick_ctrl_t       ctrl,
    input  logic [31:0]      now,
    input  logic [IDX_W-1:0] cand_pos,
    input  slot_state_t      cand_state,
    input  logic [7:0]       cand_prio,
    input  logic [31:0]      cand_arrival,
    output logic             found,
    output logic [IDX_W-1:0] best
);

    logic             found_reg;
    logic [IDX_W-1:0] best_reg;
    logic [7:0]       top_reg;
    logic [31:0]      limit_reg;
    logic             eligible;
    logic             take;

    always_comb begin
        eligible = 1'b0;
        take     = 1'b0;
        if (ctrl.cand_vld && (cand_pos != '0)) begin
            if (ctrl.mode == PICK_FREE) begin
                eligible = (cand_state == SLOT_FREE);
            end else begin
                eligible = (cand_state == SLOT_RUN);
            end
        end
        unique case (ctrl.mode) inside
            PICK_FREE, PICK_RR: begin
                take = eligible && !found_reg;
            end
            PICK_PRIO: begin
                take = eligible && (!found_reg || (cand_prio > top_reg));
            end
            PICK_FCFS: begin
                take = eligible && (cand_arrival < limit_reg);
            end
            default: begin
                take = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctrl.start) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            limit_reg <= now;
            top_reg   <= '0;
        end else if (take) begin
            best_reg  <= cand_pos;
            top_reg   <= cand_prio;
            limit_reg <= cand_arrival;
        end
    end

    assign found = found_reg;
    assign best  = best_reg;

endmodule

// ===== rtl/thread_table_scheduler_unit.sv =====
`timescale 1ns / 1ps
// thread table scheduler top level: command sequencer, slot state table and result register
//
// Create and schedule commands walk the whole slot table through one shared compare unit,
// one slot per cycle, behind a registered read of the priority and arrival memory; the input
// is not ready from such a command's transfer until it finishes. Yield and destroy touch
// only the current slot and skip the scan. The result sits in an output register, so a new
// command can be taken while the previous result still waits for m_ready; a command only
// finishes once that register is free. Slot states reset to free at once; priority and
// arrival need no clearing since they are read only for slots created since reset.
module thread_table_scheduler_unit import tts_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  tts_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output tts_out_t   m_data,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_POS  = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SLOTS - 1);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_SCAN    = 4'b0010,
        ST_DRAIN   = 4'b0100,
        ST_RESOLVE = 4'b1000
    } fsm_t;

    fsm_t             state_reg, state_next;
    logic [1:0]       mode_reg;
    tts_in_t          cmd_reg;
    pick_mode_t       pick_mode_reg, pick_mode_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             cand_vld_reg;
    logic [IDX_W-1:0] cand_pos_reg;
    slot_state_t      slot_state_reg [SLOTS];
    logic [IDX_W-1:0] cur_reg;
    logic             yv_reg;
    logic [IDX_W-1:0] ys_reg;
    logic             m_valid_reg;
    tts_out_t         out_reg;

    logic             accept;
    logic             out_free;
    logic             commit;
    pick_ctrl_t       pick_ctrl;
    logic             found;
    logic [IDX_W-1:0] best;
    logic [7:0]       rd_prio;
    logic [31:0]      rd_arrival;
    logic             mem_we;

    logic             res_ok;
    logic [IDX_W-1:0] res_idx;
    logic             st_we;
    logic [IDX_W-1:0] st_addr;
    slot_state_t      st_data;
    logic             cur_we;
    logic             yv_set;
    logic [IDX_W+TID_W-1:0] tid_ext;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_RESOLVE) && out_free;

    always_comb begin
        state_next     = state_reg;
        pick_mode_next = pick_mode_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next = '0;
                    if (s_data.cmd == CMD_CREATE || s_data.cmd == CMD_SCHED) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_RESOLVE;
                    end
                    if (s_data.cmd == CMD_CREATE) begin
                        pick_mode_next = PICK_FREE;
                        pos_next       = '0;
                    end else if (mode_reg == MODE_RR) begin
                        pick_mode_next = PICK_RR;
                        pos_next       = (cur_reg == LAST_POS) ? '0 : cur_reg + 1'b1;
                    end else if (mode_reg == MODE_PRIO) begin
                        pick_mode_next = PICK_PRIO;
                        pos_next       = '0;
                    end else begin
                        pick_mode_next = PICK_FCFS;
                        pos_next       = '0;
                    end
                end
            end
            ST_SCAN: begin
                pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result and table updates of the finishing command
    always_comb begin
        res_ok  = 1'b0;
        res_idx = '0;
        st_we   = 1'b0;
        st_addr = '0;
        st_data = SLOT_RUN;
        cur_we  = 1'b0;
        yv_set  = 1'b0;
        mem_we  = 1'b0;
        unique case (cmd_reg.cmd) inside
            CMD_CREATE: begin
                if (found) begin
                    res_ok  = 1'b1;
                    res_idx = best;
                    st_we   = 1'b1;
                    st_addr = best;
                    st_data = SLOT_RUN;
                    mem_we  = commit;
                end
            end
            CMD_YIELD, CMD_DESTROY: begin
                if (cur_reg != '0 && slot_state_reg[cur_reg] != SLOT_FREE) begin
                    res_ok  = 1'b1;
                    res_idx = cur_reg;
                    st_we   = 1'b1;
                    st_addr = cur_reg;
                    if (cmd_reg.cmd == CMD_YIELD) begin
                        st_data = SLOT_YIELD;
                        yv_set  = 1'b1;
                    end else begin
                        st_data = SLOT_FREE;
                    end
                end
            end
            CMD_SCHED: begin
                if (found) begin
                    res_ok  = 1'b1;
                    res_idx = best;
                    cur_we  = 1'b1;
                end else if (yv_reg && slot_state_reg[ys_reg] == SLOT_YIELD) begin
                    res_ok  = 1'b1;
                    res_idx = ys_reg;
                    cur_we  = 1'b1;
                    st_we   = 1'b1;
                    st_addr = ys_reg;
                    st_data = SLOT_RUN;
                end
            end
            default: begin
                res_ok = 1'b0;
            end
        endcase
    end

    assign tid_ext = {{TID_W{1'b0}}, res_idx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_RR;
            pick_mode_reg <= PICK_RR;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            cand_vld_reg  <= 1'b0;
            cur_reg       <= '0;
            yv_reg        <= 1'b0;
            ys_reg        <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_state_reg[i] <= SLOT_FREE;
            end
        end else begin
            state_reg     <= state_next;
            pick_mode_reg <= pick_mode_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            cand_vld_reg  <= (state_reg == ST_SCAN);
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (commit) begin
                if (st_we) begin
                    slot_state_reg[st_addr] <= st_data;
                end
                if (cur_we) begin
                    cur_reg <= res_idx;
                end
                if (yv_set) begin
                    yv_reg <= 1'b1;
                    ys_reg <= cur_reg;
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_data;
        end
        cand_pos_reg <= pos_reg;
        if (commit) begin
            out_reg.tid <= tid_ext[TID_W-1:0];
            out_reg.ok  <= res_ok;
        end
    end

    assign pick_ctrl.start    = accept;
    assign pick_ctrl.cand_vld = cand_vld_reg;
    assign pick_ctrl.mode     = pick_mode_reg;

    tts_slot_mem #(
        .SLOTS(SLOTS)
    ) u_slot_mem (
        .aclk       (aclk),
        .wr_en      (mem_we),
        .wr_addr    (best),
        .wr_prio    (cmd_reg.prio),
        .wr_arrival (cmd_reg.now),
        .rd_addr    (pos_reg),
        .rd_prio    (rd_prio),
        .rd_arrival (rd_arrival)
    );

    tts_picker #(
        .SLOTS(SLOTS)
    ) u_picker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (pick_ctrl),
        .now          (s_data.now),
        .cand_pos     (cand_pos_reg),
        .cand_state   (slot_state_reg[cand_pos_reg]),
        .cand_prio    (rd_prio),
        .cand_arrival (rd_arrival),
        .found        (found),
        .best         (best)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_scheduler_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_state_reg[0] == SLOT_FREE)
        else $error("scheduler slot holds a thread");

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input ready right after a transfer");

    a_result_from_resolve: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RESOLVE))
        else $error("result appeared outside resolve");

    a_fail_reports_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && !res_ok |-> res_idx == '0 && !st_we && !cur_we)
        else $error("failed command changed the table or named a slot");

    a_found_not_slot0: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESOLVE) && found && (cmd_reg.cmd == CMD_CREATE
            || cmd_reg.cmd == CMD_SCHED) |-> best != '0)
        else $error("picker selected the scheduler slot");

endmodule
